### rtl/cde_pkg.sv
// ----------------------------------------------------------------------------
// cde_pkg
// shared opcodes, status codes and sequencer state type for the deque engine
// ----------------------------------------------------------------------------
package cde_pkg;

    localparam logic [3:0] OP_PUSH_FRONT = 4'd0;
    localparam logic [3:0] OP_PUSH_BACK  = 4'd1;
    localparam logic [3:0] OP_POP_FRONT  = 4'd2;
    localparam logic [3:0] OP_POP_BACK   = 4'd3;
    localparam logic [3:0] OP_PEEK_FRONT = 4'd4;
    localparam logic [3:0] OP_PEEK_BACK  = 4'd5;
    localparam logic [3:0] OP_CLEAR      = 4'd6;
    localparam logic [3:0] OP_REVERSE    = 4'd7;
    localparam logic [3:0] OP_SORT       = 4'd8;

    localparam logic [1:0] ST_OK       = 2'd0;
    localparam logic [1:0] ST_OVERFLOW = 2'd1;
    localparam logic [1:0] ST_EMPTY    = 2'd2;

    typedef enum logic [3:0] {
        S_IDLE,
        S_RD,       // read data valid, capture it
        S_DONE,     // pop/peek data back, report
        S_REV_RA,   // reverse: read lower slot
        S_REV_RB,   // reverse: read upper slot
        S_REV_WA,   // reverse: write lower slot
        S_REV_WB,   // reverse: write upper slot
        S_SRT_RA,   // sort pass: read slot k
        S_SRT_RB,   // sort pass: read slot k+1
        S_SRT_CMP,  // compare and maybe write lower
        S_SRT_WB,   // write upper
        S_REPORT
    } t_state;

endpackage

### rtl/cde_cmp.sv
// ----------------------------------------------------------------------------
// cde_cmp
// shared signed compare unit used by the sort passes
// ----------------------------------------------------------------------------
module cde_cmp (
    input  logic signed [31:0] i_a,
    input  logic signed [31:0] i_b,
    output logic               o_gt
);
    assign o_gt = i_a > i_b;
endmodule

### rtl/circular_deque_engine.sv
// ----------------------------------------------------------------------------
// circular_deque_engine
// double-ended queue of signed words in a circular store, iterative sort/reverse
// ----------------------------------------------------------------------------
// channel   direction  ports                                  handshake
// command   in         i_opcode, i_value                      start & !busy
// result    out        o_data, o_status, o_count, o_is_empty  o_done strobe
//
// push, clear and query go to S_REPORT; pop and peek use the single read port via S_RD, S_DONE (S_REPORT if empty)
// reverse swaps pairs from the ends inward: read lower, read upper, write lower, write upper
// sort is bubble sort on the shared comparator
// reset is synchronous, active low; the store itself is not cleared
// busy is high from acceptance until the done strobe; the receiver cannot stall
// ----------------------------------------------------------------------------
module circular_deque_engine #(
    parameter int DEPTH = 128
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               start,
    output logic               busy,
    input  logic [3:0]         i_opcode,
    input  logic signed [31:0] i_value,
    output logic               o_done,
    output logic signed [31:0] o_data,
    output logic [1:0]         o_status,
    output logic [7:0]         o_count,
    output logic               o_is_empty
);
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    logic signed [31:0] r_mem [DEPTH];
    logic signed [31:0] r_rdata;

    cde_pkg::t_state r_state, n_state;
    logic [AW-1:0] r_head, n_head, r_tail, n_tail;
    logic          r_empty, n_empty;
    logic [3:0]    r_op;
    logic [CW-1:0] r_k, n_k, r_lim, n_lim;
    logic          r_swp, n_swp;
    logic [AW-1:0] r_i, n_i, r_j, n_j;
    logic signed [31:0] r_a, n_a, r_b, n_b;
    logic signed [31:0] r_data, n_data;
    logic [1:0]    r_stat, n_stat;

    // memory port controls
    logic          we;
    logic [AW-1:0] waddr, raddr;
    logic signed [31:0] wdata;

    logic          gt;
    logic [CW-1:0] cnt;

    cde_cmp u_cmp (.i_a(r_a), .i_b(r_rdata), .o_gt(gt));

    function automatic logic [AW-1:0] nxt(input logic [AW-1:0] x);
        return (x == AW'(DEPTH - 1)) ? '0 : x + AW'(1);
    endfunction
    function automatic logic [AW-1:0] prv(input logic [AW-1:0] x);
        return (x == '0) ? AW'(DEPTH - 1) : x - AW'(1);
    endfunction

    always_comb begin
        logic [AW:0] d;
        d = {1'b0, r_tail} + (r_tail < r_head ? (AW+1)'(DEPTH) : '0) - {1'b0, r_head};
        cnt = r_empty ? '0 : CW'(d) + CW'(1);
    end

    always_ff @(posedge i_clk) begin
        if (we) r_mem[waddr] <= wdata;
        r_rdata <= r_mem[raddr];
    end

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            cde_pkg::S_IDLE: begin
                if (start) begin
                    priority if (i_opcode >= cde_pkg::OP_POP_FRONT &&
                                 i_opcode <= cde_pkg::OP_PEEK_BACK && !r_empty)
                        n_state = cde_pkg::S_RD;
                    else if (i_opcode == cde_pkg::OP_REVERSE && cnt >= CW'(2))
                        n_state = cde_pkg::S_REV_RA;
                    else if (i_opcode == cde_pkg::OP_SORT && cnt >= CW'(2))
                        n_state = cde_pkg::S_SRT_RA;
                    else
                        n_state = cde_pkg::S_REPORT;
                end
            end
            cde_pkg::S_RD:     n_state = cde_pkg::S_DONE;
            cde_pkg::S_DONE:   n_state = cde_pkg::S_IDLE;
            cde_pkg::S_REV_RA: n_state = cde_pkg::S_REV_RB;
            cde_pkg::S_REV_RB: n_state = cde_pkg::S_REV_WA;
            cde_pkg::S_REV_WA: n_state = cde_pkg::S_REV_WB;
            cde_pkg::S_REV_WB:
                n_state = (r_k + CW'(1) >= r_lim) ? cde_pkg::S_REPORT : cde_pkg::S_REV_RA;
            cde_pkg::S_SRT_RA: n_state = cde_pkg::S_SRT_RB;
            cde_pkg::S_SRT_RB: n_state = cde_pkg::S_SRT_CMP;
            cde_pkg::S_SRT_CMP: begin
                if (gt) n_state = cde_pkg::S_SRT_WB;
                else if (r_k + CW'(1) < r_lim) n_state = cde_pkg::S_SRT_RA;
                else if (r_swp && r_lim > CW'(1)) n_state = cde_pkg::S_SRT_RA;
                else n_state = cde_pkg::S_REPORT;
            end
            cde_pkg::S_SRT_WB: begin
                if (r_k + CW'(1) < r_lim || r_lim > CW'(1)) n_state = cde_pkg::S_SRT_RA;
                else n_state = cde_pkg::S_REPORT;
            end
            cde_pkg::S_REPORT: n_state = cde_pkg::S_IDLE;
            default:           n_state = cde_pkg::S_IDLE;
        endcase
    end

    // datapath and memory control
    always_comb begin
        logic more;
        n_head = r_head; n_tail = r_tail; n_empty = r_empty;
        n_k = r_k; n_lim = r_lim; n_swp = r_swp; n_i = r_i; n_j = r_j;
        n_a = r_a; n_b = r_b; n_data = r_data; n_stat = r_stat;
        we = 1'b0; waddr = r_i; wdata = r_a; raddr = r_i;
        more = 1'b0;
        unique case (r_state)
            cde_pkg::S_IDLE: begin
                if (start) begin
                    n_data = '0; n_stat = cde_pkg::ST_OK;
                    n_i = r_head; n_j = r_tail; n_k = '0; n_swp = 1'b0;
                    n_lim = cnt - CW'(1);
                    raddr = (i_opcode == cde_pkg::OP_POP_FRONT ||
                             i_opcode == cde_pkg::OP_PEEK_FRONT) ? r_head : r_tail;
                    unique case (i_opcode)
                        cde_pkg::OP_PUSH_FRONT, cde_pkg::OP_PUSH_BACK: begin
                            if (cnt == CW'(DEPTH)) n_stat = cde_pkg::ST_OVERFLOW;
                            else begin
                                we = 1'b1; wdata = i_value;
                                if (r_empty) begin
                                    n_head = '0; n_tail = '0; n_empty = 1'b0; waddr = '0;
                                end else if (i_opcode == cde_pkg::OP_PUSH_FRONT) begin
                                    n_head = prv(r_head); waddr = prv(r_head);
                                end else begin
                                    n_tail = nxt(r_tail); waddr = nxt(r_tail);
                                end
                            end
                        end
                        cde_pkg::OP_POP_FRONT, cde_pkg::OP_POP_BACK,
                        cde_pkg::OP_PEEK_FRONT, cde_pkg::OP_PEEK_BACK: begin
                            if (r_empty) begin
                                n_data = -32'sd1; n_stat = cde_pkg::ST_EMPTY;
                            end else if (i_opcode == cde_pkg::OP_POP_FRONT ||
                                         i_opcode == cde_pkg::OP_POP_BACK) begin
                                if (cnt == CW'(1)) begin
                                    n_empty = 1'b1; n_head = '0; n_tail = '0;
                                end else if (i_opcode == cde_pkg::OP_POP_FRONT)
                                    n_head = nxt(r_head);
                                else
                                    n_tail = prv(r_tail);
                            end
                        end
                        cde_pkg::OP_CLEAR: begin
                            n_empty = 1'b1; n_head = '0; n_tail = '0;
                        end
                        cde_pkg::OP_REVERSE: n_lim = cnt >> 1;
                        default: ;
                    endcase
                end
            end
            // read data from the accept edge is valid here
            cde_pkg::S_RD: n_data = r_rdata;
            cde_pkg::S_DONE: ;
            cde_pkg::S_REV_RA: raddr = r_i;
            cde_pkg::S_REV_RB: begin raddr = r_j; n_a = r_rdata; end
            cde_pkg::S_REV_WA: begin
                we = 1'b1; waddr = r_i; wdata = r_rdata; n_b = r_a;
            end
            cde_pkg::S_REV_WB: begin
                we = 1'b1; waddr = r_j; wdata = r_b;
                n_i = nxt(r_i); n_j = prv(r_j); n_k = r_k + CW'(1);
            end
            cde_pkg::S_SRT_RA: raddr = r_i;
            cde_pkg::S_SRT_RB: begin raddr = nxt(r_i); n_a = r_rdata; end
            cde_pkg::S_SRT_CMP: begin
                // r_a is slot k, r_rdata is slot k+1
                if (gt) begin
                    we = 1'b1; waddr = r_i; wdata = r_rdata; n_b = r_a; n_swp = 1'b1;
                end else more = 1'b1;
            end
            cde_pkg::S_SRT_WB: begin
                we = 1'b1; waddr = nxt(r_i); wdata = r_b; more = 1'b1;
            end
            cde_pkg::S_REPORT: ;
            default: ;
        endcase
        if (more) begin
            if (r_k + CW'(1) < r_lim) begin
                n_k = r_k + CW'(1); n_i = nxt(r_i);
            end else begin
                // end of pass: last slot is now in place
                n_k = '0; n_i = r_head; n_lim = r_lim - CW'(1); n_swp = 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= cde_pkg::S_IDLE;
            r_head  <= '0;
            r_tail  <= '0;
            r_empty <= 1'b1;
        end else begin
            r_state <= n_state;
            r_head  <= n_head;
            r_tail  <= n_tail;
            r_empty <= n_empty;
        end
        if (r_state == cde_pkg::S_IDLE && start) r_op <= i_opcode;
        r_k <= n_k; r_lim <= n_lim; r_swp <= n_swp; r_i <= n_i; r_j <= n_j;
        r_a <= n_a; r_b <= n_b; r_data <= n_data; r_stat <= n_stat;
    end

    // outputs
    always_comb begin
        busy   = (r_state != cde_pkg::S_IDLE);
        o_done = (r_state == cde_pkg::S_REPORT) || (r_state == cde_pkg::S_DONE);
        o_data = r_data;
        o_status   = r_stat;
        o_count    = 8'(cnt);
        o_is_empty = r_empty;
    end

    a_done_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> busy) else $error("done while idle");
    a_empty_ptrs: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_empty |-> (r_head == '0 && r_tail == '0)) else $error("empty with pointers");
    a_sort_nochange: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (busy && r_op == cde_pkg::OP_SORT) |=> $stable(r_head) && $stable(r_tail))
        else $error("sort moved pointers");
    a_done_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |=> !busy) else $error("busy after done");

endmodule
